[rtl/gwcc_pkg.sv]
// Shared types, constants and defaults for the ground window colour classifier.
package gwcc_pkg;

	localparam int WINDOW_DEPTH_DEF = 5;
	localparam int SAMPLE_BITS_DEF  = 12;

	localparam int THR_BITS       = 12;
	localparam int LIMIT_BITS     = 4;
	localparam int COUNT_BITS     = 4;
	localparam int CLASS_BITS     = 2;
	localparam int CFG_DATA_BITS  = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CHANNELS       = 3;

	localparam logic [THR_BITS-1:0]   BLACK_THR_RST = 12'd123;
	localparam logic [THR_BITS-1:0]   WHITE_THR_RST = 12'd3482;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RST     = 4'd10;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 4'd15;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BLACK_THR = 2'd0,
		REG_WHITE_THR = 2'd1,
		REG_LIMIT     = 2'd2
	} cfg_reg_t;

	typedef enum logic [CLASS_BITS-1:0] {
		CLASS_BLACK = 2'd0,
		CLASS_GREY  = 2'd1,
		CLASS_WHITE = 2'd2
	} floor_class_t;

	typedef struct packed {
		logic [THR_BITS-1:0]   black_threshold;
		logic [THR_BITS-1:0]   white_threshold;
		logic [LIMIT_BITS-1:0] count_limit;
	} cfg_t;

endpackage

[rtl/gwcc_if.sv]
// Valid/ready channel interfaces for sensor samples and classification results.
interface gwcc_in_if #(
	parameter int SAMPLE_BITS = gwcc_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_level;
	logic [SAMPLE_BITS-1:0] center_level;
	logic [SAMPLE_BITS-1:0] right_level;

	modport source (output valid, left_level, center_level, right_level, input ready);
	modport sink   (input valid, left_level, center_level, right_level, output ready);
endinterface

interface gwcc_out_if;
	logic                                valid;
	logic                                ready;
	logic [gwcc_pkg::CLASS_BITS-1:0]     floor_class;
	logic [gwcc_pkg::COUNT_BITS-1:0]     black_count;
	logic [gwcc_pkg::COUNT_BITS-1:0]     white_count;

	modport source (output valid, floor_class, black_count, white_count, input ready);
	modport sink   (input valid, floor_class, black_count, white_count, output ready);
endinterface

[rtl/ground_window_color_classifier.sv]
// Each accepted sample beat is classified combinationally and its result is held in the result register.
// Throughput: one sample beat per cycle; the window shift line and the result
// register form two stages, and a held result stalls input only when both are full.
// Reset (arst_n low, asynchronous): window empty, no result pending,
// thresholds 123 and 3482, count limit 10.
module ground_window_color_classifier #(
	parameter int WINDOW_DEPTH = gwcc_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = gwcc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gwcc_in_if.sink                             sample,
	gwcc_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [gwcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gwcc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	gwcc_pkg::cfg_t                                              cfg_q;
	logic [WINDOW_DEPTH-1:0][gwcc_pkg::CHANNELS*SAMPLE_BITS-1:0] entries;
	logic [WINDOW_DEPTH-1:0]                                     entry_vld;
	gwcc_pkg::floor_class_t                                      calc_class;
	logic [gwcc_pkg::COUNT_BITS-1:0]                             calc_black;
	logic [gwcc_pkg::COUNT_BITS-1:0]                             calc_white;
	logic                                                        shift_en;
	logic                                                        advance;
	logic                                                        calc_valid_q;
	logic                                                        res_valid_q;
	gwcc_pkg::floor_class_t                                      res_class_q;
	logic [gwcc_pkg::COUNT_BITS-1:0]                             res_black_q;
	logic [gwcc_pkg::COUNT_BITS-1:0]                             res_white_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_threshold <= gwcc_pkg::BLACK_THR_RST;
			cfg_q.white_threshold <= gwcc_pkg::WHITE_THR_RST;
			cfg_q.count_limit     <= gwcc_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gwcc_pkg::REG_BLACK_THR: cfg_q.black_threshold <= cfg_data;
				gwcc_pkg::REG_WHITE_THR: cfg_q.white_threshold <= cfg_data;
				gwcc_pkg::REG_LIMIT:
					cfg_q.count_limit <= cfg_data[gwcc_pkg::LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// advance the window result into the output register when it is free
	assign advance      = !res_valid_q || result.ready;
	assign sample.ready = !calc_valid_q || advance;
	assign shift_en     = sample.valid && sample.ready;

	gwcc_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (shift_en),
		.sample    ({sample.right_level, sample.center_level, sample.left_level}),
		.entries   (entries),
		.entry_vld (entry_vld)
	);

	gwcc_count #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_count (
		.entries     (entries),
		.entry_vld   (entry_vld),
		.cfg         (cfg_q),
		.floor_class (calc_class),
		.black_count (calc_black),
		.white_count (calc_white)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (shift_en) begin
				calc_valid_q <= 1'b1;
			end else if (advance) begin
				calc_valid_q <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= calc_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && calc_valid_q) begin
			res_class_q <= calc_class;
			res_black_q <= calc_black;
			res_white_q <= calc_white;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.floor_class = res_class_q;
	assign result.black_count = res_black_q;
	assign result.white_count = res_white_q;

	// window entries fill from the newest end without gaps
	a_vld_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((entry_vld & (entry_vld + WINDOW_DEPTH'(1))) == '0))
		else $error("window valid bits not contiguous");

	// every accepted beat is followed by a result on offer from the result register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> ##1 result.valid)
		else $error("result missing after accepted sample beat");

	// grey only when neither count exceeds the limit
	a_grey_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.floor_class == gwcc_pkg::CLASS_GREY)) |->
		((result.black_count <= cfg_q.count_limit) &&
		 (result.white_count <= cfg_q.count_limit)))
		else $error("grey class with count above limit");

	// a black result must carry a nonzero black count
	a_black_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.floor_class == gwcc_pkg::CLASS_BLACK)) |->
		(result.black_count != '0))
		else $error("black class with zero black count");

endmodule

[rtl/gwcc_window.sv]
// Shift line holding the most recent samples with a valid bit per entry.
module gwcc_window #(
	parameter int WINDOW_DEPTH = gwcc_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = gwcc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  shift_en,
	input  logic [gwcc_pkg::CHANNELS*SAMPLE_BITS-1:0]             sample,
	output logic [WINDOW_DEPTH-1:0][gwcc_pkg::CHANNELS*SAMPLE_BITS-1:0] entries,
	output logic [WINDOW_DEPTH-1:0]                               entry_vld
);

	logic [WINDOW_DEPTH-1:0][gwcc_pkg::CHANNELS*SAMPLE_BITS-1:0] entry_q;
	logic [WINDOW_DEPTH-1:0]                                     vld_q;

	// newest sample enters at entry 0, the oldest falls off the end
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q[0] <= sample;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				entry_q[i] <= entry_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (shift_en) begin
			vld_q[0] <= 1'b1;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign entries   = entry_q;
	assign entry_vld = vld_q;

endmodule

[rtl/gwcc_count.sv]
// Per-value threshold tests, window counts and floor class decision.
module gwcc_count #(
	parameter int WINDOW_DEPTH = gwcc_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = gwcc_pkg::SAMPLE_BITS_DEF
) (
	input  logic [WINDOW_DEPTH-1:0][gwcc_pkg::CHANNELS*SAMPLE_BITS-1:0] entries,
	input  logic [WINDOW_DEPTH-1:0]                               entry_vld,
	input  gwcc_pkg::cfg_t                                        cfg,
	output gwcc_pkg::floor_class_t                                floor_class,
	output logic [gwcc_pkg::COUNT_BITS-1:0]                       black_count,
	output logic [gwcc_pkg::COUNT_BITS-1:0]                       white_count
);

	localparam int CMP_BITS = (SAMPLE_BITS > gwcc_pkg::THR_BITS) ?
		SAMPLE_BITS : gwcc_pkg::THR_BITS;
	localparam int CNT_BITS = $clog2(gwcc_pkg::CHANNELS * WINDOW_DEPTH + 1);
	localparam int SAT_BITS = (CNT_BITS > gwcc_pkg::COUNT_BITS) ?
		CNT_BITS : gwcc_pkg::COUNT_BITS + 1;
	localparam int ENT_BITS = 2;

	logic [WINDOW_DEPTH-1:0][ENT_BITS-1:0] ent_black;
	logic [WINDOW_DEPTH-1:0][ENT_BITS-1:0] ent_white;
	logic [CNT_BITS-1:0]                   black_sum;
	logic [CNT_BITS-1:0]                   white_sum;
	logic [SAT_BITS-1:0]                   black_ext;
	logic [SAT_BITS-1:0]                   white_ext;
	logic [SAT_BITS-1:0]                   limit_ext;

	// black is tested first, so a value meeting both tests is black only
	always_comb begin
		logic [CMP_BITS-1:0] v;
		logic                is_black;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			ent_black[i] = '0;
			ent_white[i] = '0;
			for (int j = 0; j < gwcc_pkg::CHANNELS; j++) begin
				v = CMP_BITS'(entries[i][j*SAMPLE_BITS +: SAMPLE_BITS]);
				is_black = v < CMP_BITS'(cfg.black_threshold);
				if (entry_vld[i] && is_black) begin
					ent_black[i] = ent_black[i] + ENT_BITS'(1);
				end else if (entry_vld[i] && (v > CMP_BITS'(cfg.white_threshold))) begin
					ent_white[i] = ent_white[i] + ENT_BITS'(1);
				end
			end
		end
	end

	always_comb begin
		black_sum = '0;
		white_sum = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			black_sum = black_sum + CNT_BITS'(ent_black[i]);
			white_sum = white_sum + CNT_BITS'(ent_white[i]);
		end
	end

	assign black_ext = SAT_BITS'(black_sum);
	assign white_ext = SAT_BITS'(white_sum);
	assign limit_ext = SAT_BITS'(cfg.count_limit);

	always_comb begin
		if (black_ext > limit_ext) begin
			floor_class = gwcc_pkg::CLASS_BLACK;
		end else if (white_ext > limit_ext) begin
			floor_class = gwcc_pkg::CLASS_WHITE;
		end else begin
			floor_class = gwcc_pkg::CLASS_GREY;
		end
	end

	// clamp the reported counts; the decision above uses the exact ones
	assign black_count = (black_ext > SAT_BITS'(gwcc_pkg::COUNT_MAX)) ?
		gwcc_pkg::COUNT_MAX : black_ext[gwcc_pkg::COUNT_BITS-1:0];
	assign white_count = (white_ext > SAT_BITS'(gwcc_pkg::COUNT_MAX)) ?
		gwcc_pkg::COUNT_MAX : white_ext[gwcc_pkg::COUNT_BITS-1:0];

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ground window colour classifier.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 40;
	localparam int CHUNKS      = 12;
	localparam int CHUNK_ITEMS = 100;
	localparam int PEND_DEPTH  = 16;
	localparam int MAX_ROWS    = 48;
	localparam logic [gwcc_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [gwcc_pkg::SAMPLE_BITS_DEF-1:0] left_level;
		logic [gwcc_pkg::SAMPLE_BITS_DEF-1:0] center_level;
		logic [gwcc_pkg::SAMPLE_BITS_DEF-1:0] right_level;
	} sample_t;

	typedef struct packed {
		gwcc_pkg::floor_class_t          cls;
		logic [gwcc_pkg::COUNT_BITS-1:0] blacks;
		logic [gwcc_pkg::COUNT_BITS-1:0] whites;
	} floor_result_t;

	typedef enum bit [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                            kind;
		logic [gwcc_pkg::CFG_INDEX_BITS-1:0]  idx;
		logic [gwcc_pkg::CFG_DATA_BITS-1:0]   data;
		sample_t                              smp;
		floor_result_t                        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [gwcc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [gwcc_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	gwcc_in_if #(.SAMPLE_BITS(gwcc_pkg::SAMPLE_BITS_DEF)) sample_ch ();
	gwcc_out_if result_ch ();

	ground_window_color_classifier #(
		.WINDOW_DEPTH(gwcc_pkg::WINDOW_DEPTH_DEF),
		.SAMPLE_BITS (gwcc_pkg::SAMPLE_BITS_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predicted register file and sample window
	logic [gwcc_pkg::THR_BITS-1:0]   blk_thr = gwcc_pkg::BLACK_THR_RST;
	logic [gwcc_pkg::THR_BITS-1:0]   wht_thr = gwcc_pkg::WHITE_THR_RST;
	logic [gwcc_pkg::LIMIT_BITS-1:0] lim     = gwcc_pkg::LIMIT_RST;
	sample_t                         win_mem[gwcc_pkg::WINDOW_DEPTH_DEF];
	int                              win_fill = 0;
	int                              win_next = 0;

	floor_result_t pend_mem[PEND_DEPTH];
	int            pend_wr = 0;
	int            pend_rd = 0;
	stim_row_t     stim_rows[MAX_ROWS];
	int            row_cnt = 0;

	int mismatch_cnt  = 0;
	int cycle_cnt     = 0;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int hold_requests = 0;
	int holds_done    = 0;
	int hold_left     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_cnt < 40)
			$display("%0t ns: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			flag_mismatch("cycle limit reached");
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void apply_reg(input logic [gwcc_pkg::CFG_INDEX_BITS-1:0] idx,
	                                  input logic [gwcc_pkg::CFG_DATA_BITS-1:0] data);
		case (idx)
			gwcc_pkg::REG_BLACK_THR: blk_thr = data[gwcc_pkg::THR_BITS-1:0];
			gwcc_pkg::REG_WHITE_THR: wht_thr = data[gwcc_pkg::THR_BITS-1:0];
			gwcc_pkg::REG_LIMIT:     lim     = data[gwcc_pkg::LIMIT_BITS-1:0];
			default: ;
		endcase
	endfunction

	// slide the window on and count every stored level against the current thresholds
	function automatic floor_result_t classify_window(input sample_t smp);
		int blacks;
		int whites;
		logic [gwcc_pkg::SAMPLE_BITS_DEF-1:0] v;
		floor_result_t res;
		blacks = 0;
		whites = 0;
		win_mem[win_next] = smp;
		win_next = (win_next == gwcc_pkg::WINDOW_DEPTH_DEF - 1) ? 0 : win_next + 1;
		if (win_fill < gwcc_pkg::WINDOW_DEPTH_DEF)
			win_fill++;
		for (int i = 0; i < win_fill; i++) begin
			for (int ch = 0; ch < gwcc_pkg::CHANNELS; ch++) begin
				v = win_mem[i][ch*gwcc_pkg::SAMPLE_BITS_DEF +: gwcc_pkg::SAMPLE_BITS_DEF];
				if (v < blk_thr)
					blacks++;
				else if (v > wht_thr)
					whites++;
			end
		end
		if (blacks > lim)
			res.cls = gwcc_pkg::CLASS_BLACK;
		else if (whites > lim)
			res.cls = gwcc_pkg::CLASS_WHITE;
		else
			res.cls = gwcc_pkg::CLASS_GREY;
		res.blacks = (blacks > gwcc_pkg::COUNT_MAX) ? gwcc_pkg::COUNT_MAX :
			gwcc_pkg::COUNT_BITS'(blacks);
		res.whites = (whites > gwcc_pkg::COUNT_MAX) ? gwcc_pkg::COUNT_MAX :
			gwcc_pkg::COUNT_BITS'(whites);
		return res;
	endfunction

	// bias 0 leans black, 1 leans white, anything else is mixed
	function automatic logic [gwcc_pkg::SAMPLE_BITS_DEF-1:0] pick_level(input int bias);
		int pick;
		pick = $urandom_range(7);
		if (bias == 0 && pick < 5)
			pick = 2;
		else if (bias == 1 && pick < 5)
			pick = 3;
		case (pick)
			2: return (blk_thr == 0) ? 12'd0 : 12'($urandom_range(int'(blk_thr) - 1));
			3: return (wht_thr == 12'hFFF) ? 12'hFFF :
				12'($urandom_range(4095, int'(wht_thr) + 1));
			4: begin
				case ($urandom_range(3))
					0: return blk_thr;
					1: return 12'(blk_thr - 12'd1);
					2: return wht_thr;
					default: return 12'(wht_thr + 12'd1);
				endcase
			end
			5: return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	function automatic void add_row(input row_kind_t kind,
	                                input logic [gwcc_pkg::CFG_INDEX_BITS-1:0] idx,
	                                input logic [gwcc_pkg::CFG_DATA_BITS-1:0] data,
	                                input sample_t smp, input floor_result_t want);
		stim_rows[row_cnt].kind = kind;
		stim_rows[row_cnt].idx  = idx;
		stim_rows[row_cnt].data = data;
		stim_rows[row_cnt].smp  = smp;
		stim_rows[row_cnt].want = want;
		row_cnt++;
	endfunction

	function automatic void add_write(input logic [gwcc_pkg::CFG_INDEX_BITS-1:0] idx,
	                                  input logic [gwcc_pkg::CFG_DATA_BITS-1:0] data);
		add_row(ROW_WRITE, idx, data, '0, '0);
	endfunction

	function automatic void add_sample(input int l, input int c, input int r);
		add_row(ROW_SAMPLE, '0, '0, {12'(l), 12'(c), 12'(r)}, '0);
	endfunction

	function automatic void add_checked(input int l, input int c, input int r,
	                                    input gwcc_pkg::floor_class_t cls,
	                                    input int nb, input int nw);
		add_row(ROW_CHECKED, '0, '0, {12'(l), 12'(c), 12'(r)}, {cls, 4'(nb), 4'(nw)});
	endfunction

	task automatic send_sample(input sample_t smp, input bit given, input floor_result_t want);
		floor_result_t due;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.left_level   <= smp.left_level;
		sample_ch.center_level <= smp.center_level;
		sample_ch.right_level  <= smp.right_level;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		due = classify_window(smp);
		pend_mem[pend_wr % PEND_DEPTH] = given ? want : due;
		pend_wr++;
	endtask

	// drop valid and let every pending result drain before touching a register
	task automatic settle_idle();
		sample_ch.valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gwcc_pkg::CFG_INDEX_BITS-1:0] idx,
	                         input logic [gwcc_pkg::CFG_DATA_BITS-1:0] data);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
	endtask

	// receiver: random stalls plus long hold-offs on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		floor_result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pend_wr == pend_rd) begin
				flag_mismatch("result beat with nothing pending");
			end else begin
				want = pend_mem[pend_rd % PEND_DEPTH];
				pend_rd++;
				if (result_ch.floor_class !== want.cls)
					flag_mismatch($sformatf("floor_class %0d, want %0d",
						result_ch.floor_class, want.cls));
				if (result_ch.black_count !== want.blacks)
					flag_mismatch($sformatf("black_count %0d, want %0d",
						result_ch.black_count, want.blacks));
				if (result_ch.white_count !== want.whites)
					flag_mismatch($sformatf("white_count %0d, want %0d",
						result_ch.white_count, want.whites));
			end
		end
	end

	initial begin
		sample_t smp;
		int streak;
		logic [gwcc_pkg::CFG_DATA_BITS-1:0] b_val;
		logic [gwcc_pkg::CFG_DATA_BITS-1:0] w_val;
		logic [gwcc_pkg::CFG_DATA_BITS-1:0] l_val;

		arst_n                 <= 1'b0;
		sample_ch.valid        <= 1'b0;
		sample_ch.left_level   <= '0;
		sample_ch.center_level <= '0;
		sample_ch.right_level  <= '0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_data               <= '0;

		// window filling from empty, threshold edges, saturated windows
		add_checked(0, 4095, 2000, gwcc_pkg::CLASS_GREY, 1, 1);
		add_checked(122, 123, 3482, gwcc_pkg::CLASS_GREY, 2, 1);
		add_sample(3483, 4094, 1);
		repeat (4) add_sample(0, 0, 0);
		add_checked(0, 0, 0, gwcc_pkg::CLASS_BLACK, 15, 0);
		repeat (4) add_sample(4095, 4095, 4095);
		add_checked(4095, 4095, 4095, gwcc_pkg::CLASS_WHITE, 0, 15);
		add_write(gwcc_pkg::REG_LIMIT, 12'd15);
		add_checked(4095, 4095, 4095, gwcc_pkg::CLASS_GREY, 0, 15);
		// upper data bits must be masked off the limit
		add_write(gwcc_pkg::REG_LIMIT, 12'hFF0);
		add_checked(4095, 4095, 4095, gwcc_pkg::CLASS_WHITE, 0, 15);
		// overlapping thresholds: black takes precedence
		add_write(gwcc_pkg::REG_BLACK_THR, 12'd4000);
		add_write(gwcc_pkg::REG_WHITE_THR, 12'd100);
		add_sample(2000, 2000, 2000);
		add_sample(4095, 50, 4000);
		add_write(gwcc_pkg::REG_BLACK_THR, 12'd0);
		add_write(gwcc_pkg::REG_WHITE_THR, 12'd4095);
		add_checked(0, 4095, 2048, gwcc_pkg::CLASS_GREY, 0, 0);
		add_write(REG_UNUSED, 12'hFFF);
		add_checked(4095, 0, 1, gwcc_pkg::CLASS_GREY, 0, 0);
		add_write(gwcc_pkg::REG_BLACK_THR, gwcc_pkg::BLACK_THR_RST);
		add_write(gwcc_pkg::REG_WHITE_THR, gwcc_pkg::WHITE_THR_RST);
		add_write(gwcc_pkg::REG_LIMIT, 12'(gwcc_pkg::LIMIT_RST));
		add_sample(123, 3482, 122);
		add_sample(2730, 1365, 3483);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < row_cnt; i++) begin
			case (stim_rows[i].kind)
				ROW_WRITE:   write_reg(stim_rows[i].idx, stim_rows[i].data);
				ROW_CHECKED: send_sample(stim_rows[i].smp, 1'b1, stim_rows[i].want);
				default:     send_sample(stim_rows[i].smp, 1'b0, '0);
			endcase
		end

		streak = 2;
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk / 4)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (chunk % 5)
				0: begin
					b_val = gwcc_pkg::BLACK_THR_RST;
					w_val = gwcc_pkg::WHITE_THR_RST;
					l_val = {8'($urandom_range(255)), gwcc_pkg::LIMIT_RST};
				end
				1: begin
					b_val = 12'd0;
					w_val = 12'd0;
					l_val = {8'($urandom_range(255)), 4'd0};
				end
				2: begin
					b_val = 12'hFFF;
					w_val = 12'hFFF;
					l_val = {8'($urandom_range(255)), 4'hF};
				end
				3: begin
					b_val = 12'($urandom_range(4095));
					w_val = 12'($urandom_range(4095));
					l_val = 12'($urandom_range(4095));
				end
				default: begin
					b_val = 12'($urandom_range(4095, 2048));
					w_val = 12'($urandom_range(2047));
					l_val = {8'($urandom_range(255)), 4'($urandom_range(12, 3))};
				end
			endcase
			write_reg(gwcc_pkg::REG_BLACK_THR, b_val);
			write_reg(gwcc_pkg::REG_WHITE_THR, w_val);
			write_reg(gwcc_pkg::REG_LIMIT, l_val);
			// hold the result side off so the block fills and back-pressures
			if (chunk == 2 || chunk == 9)
				hold_requests++;
			repeat (CHUNK_ITEMS) begin
				if ($urandom_range(7) == 0)
					streak = $urandom_range(2);
				smp = {pick_level(streak), pick_level(streak), pick_level(streak)};
				send_sample(smp, 1'b0, '0);
			end
		end

		settle_idle();
		repeat (4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
